// ===== src/keyed_packed_list_table_top_macros.svh =====
`ifndef KEYED_PACKED_LIST_TABLE_TOP_MACROS_SVH
`define KEYED_PACKED_LIST_TABLE_TOP_MACROS_SVH

// Clocked property check, quiet while reset is held
`define KPLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check of a condition that must never hold
`define KPLT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== src/kplt_pkg.sv =====
package kplt_pkg;

	localparam int DEPTH_DEF        = 64;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int CMD_W  = 3;
	localparam int KEY_W  = 31;
	localparam int PAY_W  = 32;
	localparam int POS_W  = 6;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 7;

	localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FIND       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE_KEY = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE_IDX = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_IDX   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_RESOLVE
	} state_t;

	typedef struct packed {
		logic             match_en;
		logic             by_key;
		logic             by_index;
		logic             append_en;
		logic             shift_en;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

endpackage

// ===== src/kplt_req_if.sv =====
interface kplt_req_if;
	logic                        valid;
	logic                        ready;
	logic [kplt_pkg::CMD_W-1:0]  command;
	logic [kplt_pkg::KEY_W-1:0]  entry_key;
	logic [kplt_pkg::PAY_W-1:0]  entry_payload;
	logic [kplt_pkg::POS_W-1:0]  position;

	modport source (output valid, command, entry_key, entry_payload, position, input ready);
	modport sink (input valid, command, entry_key, entry_payload, position, output ready);
endinterface

// ===== src/kplt_rsp_if.sv =====
interface kplt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [kplt_pkg::STAT_W-1:0] status;
	logic [kplt_pkg::POS_W-1:0]  found_position;
	logic [kplt_pkg::KEY_W-1:0]  found_key;
	logic [kplt_pkg::PAY_W-1:0]  found_payload;
	logic [kplt_pkg::CNT_W-1:0]  entry_count;

	modport source (output valid, status, found_position, found_key, found_payload,
		entry_count, input ready);
	modport sink (input valid, status, found_position, found_key, found_payload,
		entry_count, output ready);
endinterface

// ===== src/kplt_cell.sv =====
module kplt_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7,
	parameter int EW  = 6,
	parameter int SW  = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kplt_pkg::cell_ctl_t        ctl,
	input  logic [CW-1:0]              count,
	input  logic [SW-1:0]              new_pay,
	input  logic                       ge,
	input  logic [kplt_pkg::KEY_W-1:0] nb_key,
	input  logic [SW-1:0]              nb_pay,
	output logic [kplt_pkg::KEY_W-1:0] key,
	output logic [SW-1:0]              pay,
	output logic                       hit
);

	logic [kplt_pkg::KEY_W-1:0] key_q;
	logic [SW-1:0]              pay_q;
	logic                       hit_s2;
	logic                       below;
	logic                       at_end;
	logic                       pos_eq;
	logic                       hit_d;

	assign below  = CW'(IDX) < count;
	assign at_end = CW'(IDX) == count;
	assign pos_eq = EW'(ctl.pos) == EW'(IDX);
	assign hit_d  = below && ((ctl.by_key && (key_q == ctl.key)) || (ctl.by_index && pos_eq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else if (ctl.match_en) begin
			hit_s2 <= hit_d;
		end
	end

	// append lands at the tail; removal pulls the neighbour down
	always_ff @(posedge clk) begin
		if (ctl.append_en && at_end) begin
			key_q <= ctl.key;
			pay_q <= new_pay;
		end else if (ctl.shift_en && ge) begin
			key_q <= nb_key;
			pay_q <= nb_pay;
		end
	end

	assign key = key_q;
	assign pay = pay_q;
	assign hit = hit_s2;

endmodule

// ===== src/keyed_packed_list_table_top.sv =====
// Request words pass the match state (hit register of the cell row) and the resolve state
// (select and shift through the cells); resolve writes the output register and waits while
// it holds an untaken result. A new word is taken in idle, or in resolve as the last commits.
// A new request is taken while an earlier result still waits in the output register.
// Reset: asynchronous, active low; clears the entry count, control and output valid.
// Cell contents are not reset and hold nothing meaningful until appended.
`include "keyed_packed_list_table_top_macros.svh"

module keyed_packed_list_table_top #(
	parameter int DEPTH        = kplt_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = kplt_pkg::PAYLOAD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	kplt_req_if.sink   req,
	kplt_rsp_if.source rsp
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int EW  = (AW > kplt_pkg::POS_W) ? AW : kplt_pkg::POS_W;
	localparam int CEW = (CW > kplt_pkg::CNT_W) ? CW : kplt_pkg::CNT_W;
	localparam int SW  = (PAYLOAD_BITS < kplt_pkg::PAY_W) ? PAYLOAD_BITS : kplt_pkg::PAY_W;

	kplt_pkg::state_t state_q, state_d;

	logic [kplt_pkg::CMD_W-1:0]  cmd_s1;
	logic [kplt_pkg::KEY_W-1:0]  key_s1;
	logic [SW-1:0]               pay_s1;
	logic [kplt_pkg::POS_W-1:0]  pos_s1;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               count_d;

	logic                        out_valid_q;
	logic [kplt_pkg::STAT_W-1:0] out_status_q;
	logic [kplt_pkg::POS_W-1:0]  out_pos_q;
	logic [kplt_pkg::KEY_W-1:0]  out_key_q;
	logic [kplt_pkg::PAY_W-1:0]  out_pay_q;
	logic [kplt_pkg::CNT_W-1:0]  out_count_q;

	logic                        req_fire;
	logic                        out_free;
	logic                        resolve_go;
	logic                        ready_c;
	logic                        by_key;
	logic                        by_index;
	logic                        is_remove;
	logic                        full;
	logic                        any_hit;
	logic                        report;

	logic [DEPTH-1:0]            v;
	logic [DEPTH-1:0]            oh;
	logic [DEPTH-1:0]            ge;
	logic [kplt_pkg::KEY_W-1:0]  cell_key [DEPTH];
	logic [SW-1:0]               cell_pay [DEPTH];
	logic [AW-1:0]               at;
	logic [EW-1:0]               at_ext;
	logic [CEW-1:0]              cnt_ext;
	logic [kplt_pkg::KEY_W-1:0]  sel_key;
	logic [SW-1:0]               sel_pay;
	logic [kplt_pkg::STAT_W-1:0] status_c;

	kplt_pkg::cell_ctl_t         ctl;

	assign req_fire   = req.valid && req.ready;
	assign out_free   = !out_valid_q || rsp.ready;
	assign resolve_go = (state_q == kplt_pkg::S_RESOLVE) && out_free;

	assign by_key    = (cmd_s1 == kplt_pkg::CMD_FIND) || (cmd_s1 == kplt_pkg::CMD_REMOVE_KEY);
	assign by_index  = (cmd_s1 == kplt_pkg::CMD_REMOVE_IDX) || (cmd_s1 == kplt_pkg::CMD_READ_IDX);
	assign is_remove = (cmd_s1 == kplt_pkg::CMD_REMOVE_KEY) || (cmd_s1 == kplt_pkg::CMD_REMOVE_IDX);
	assign full      = count_q == CW'(DEPTH);

	assign any_hit = |v;
	assign oh      = v & (~v + DEPTH'(1));
	assign ge      = ~(oh - DEPTH'(1));
	assign report  = (by_key || by_index) && any_hit;

	always_comb begin
		ctl.match_en  = state_q == kplt_pkg::S_MATCH;
		ctl.by_key    = by_key;
		ctl.by_index  = by_index;
		ctl.append_en = resolve_go && (cmd_s1 == kplt_pkg::CMD_APPEND) && !full;
		ctl.shift_en  = resolve_go && is_remove && any_hit;
		ctl.key       = key_s1;
		ctl.pos       = pos_s1;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [kplt_pkg::KEY_W-1:0] nb_key;
		logic [SW-1:0]              nb_pay;

		if (i == DEPTH - 1) begin : g_tail
			assign nb_key = '0;
			assign nb_pay = '0;
		end else begin : g_body
			assign nb_key = cell_key[i+1];
			assign nb_pay = cell_pay[i+1];
		end

		kplt_cell #(
			.IDX (i),
			.CW  (CW),
			.EW  (EW),
			.SW  (SW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.count   (count_q),
			.new_pay (pay_s1),
			.ge      (ge[i]),
			.nb_key  (nb_key),
			.nb_pay  (nb_pay),
			.key     (cell_key[i]),
			.pay     (cell_pay[i]),
			.hit     (v[i])
		);
	end

	always_comb begin
		at      = '0;
		sel_key = '0;
		sel_pay = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (oh[i]) begin
				at      = at | AW'(i);
				sel_key = sel_key | cell_key[i];
				sel_pay = sel_pay | cell_pay[i];
			end
		end
	end

	always_comb begin
		case (cmd_s1)
			kplt_pkg::CMD_APPEND:     status_c = full ? kplt_pkg::STAT_FULL : kplt_pkg::STAT_OK;
			kplt_pkg::CMD_FIND,
			kplt_pkg::CMD_REMOVE_KEY: status_c = any_hit ? kplt_pkg::STAT_OK
				: kplt_pkg::STAT_NOT_FOUND;
			kplt_pkg::CMD_REMOVE_IDX,
			kplt_pkg::CMD_READ_IDX:   status_c = any_hit ? kplt_pkg::STAT_OK
				: kplt_pkg::STAT_RANGE;
			default:                  status_c = kplt_pkg::STAT_OK;
		endcase
	end

	always_comb begin
		if (ctl.append_en) begin
			count_d = count_q + CW'(1);
		end else if (ctl.shift_en) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	assign at_ext  = EW'(at);
	assign cnt_ext = CEW'(count_d);

	always_comb begin
		state_d = state_q;
		ready_c = 1'b0;
		case (state_q)
			kplt_pkg::S_IDLE: begin
				ready_c = 1'b1;
				if (req.valid) begin
					state_d = kplt_pkg::S_MATCH;
				end
			end
			kplt_pkg::S_MATCH: begin
				state_d = kplt_pkg::S_RESOLVE;
			end
			kplt_pkg::S_RESOLVE: begin
				ready_c = out_free;
				if (out_free) begin
					state_d = req.valid ? kplt_pkg::S_MATCH : kplt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kplt_pkg::S_IDLE;
			end
		endcase
	end

	assign req.ready = ready_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kplt_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (resolve_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1 <= req.command;
			key_s1 <= req.entry_key;
			pay_s1 <= req.entry_payload[SW-1:0];
			pos_s1 <= req.position;
		end
	end

	always_ff @(posedge clk) begin
		if (resolve_go) begin
			out_status_q <= status_c;
			out_pos_q    <= report ? at_ext[kplt_pkg::POS_W-1:0] : '0;
			out_key_q    <= report ? sel_key : '0;
			out_pay_q    <= report ? kplt_pkg::PAY_W'(sel_pay) : '0;
			out_count_q  <= cnt_ext[kplt_pkg::CNT_W-1:0];
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.found_position = out_pos_q;
	assign rsp.found_key      = out_key_q;
	assign rsp.found_payload  = out_pay_q;
	assign rsp.entry_count    = out_count_q;

	`KPLT_NEVER(a_count_bound, count_q > CW'(DEPTH), "entry count beyond depth")
	`KPLT_ASSERT(a_accept_match, req_fire |=> state_q == kplt_pkg::S_MATCH, "accepted word not matched")
	`KPLT_ASSERT(a_index_onehot, (state_q == kplt_pkg::S_RESOLVE && by_index) |-> $onehot0(v), "index hit not one-hot")
	`KPLT_ASSERT(a_out_from_resolve, $rose(out_valid_q) |-> $past(state_q == kplt_pkg::S_RESOLVE), "result without resolve")
	`KPLT_ASSERT(a_count_on_commit, (count_q != $past(count_q)) |-> $past(resolve_go), "count moved outside commit")

endmodule

// ===== tb/kplt_checker.sv =====
module kplt_checker #(
	parameter int DEPTH        = kplt_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = kplt_pkg::PAYLOAD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	kplt_req_if        req,
	kplt_rsp_if        rsp,
	output int         fail_count,
	output int         pending
);
	import kplt_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  found_position;
		logic [KEY_W-1:0]  found_key;
		logic [PAY_W-1:0]  found_payload;
		logic [CNT_W-1:0]  entry_count;
	} list_answer_t;

	localparam logic [PAY_W-1:0] PAY_KEEP =
		(PAYLOAD_BITS >= PAY_W) ? '1 : PAY_W'((64'd1 << PAYLOAD_BITS) - 64'd1);

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [PAY_W-1:0] pay_mem [DEPTH];
	int               held;
	int               fails;
	list_answer_t     answer_q [$];

	function automatic list_answer_t apply_command(logic [CMD_W-1:0] cmd,
		logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay, logic [POS_W-1:0] pos);
		list_answer_t a;
		int           at;
		bit           hit;
		a   = '0;
		at  = 0;
		hit = 1'b0;
		a.status = STAT_OK;
		case (cmd)
			CMD_APPEND: begin
				if (held >= DEPTH) begin
					a.status = STAT_FULL;
				end else begin
					key_mem[held] = key;
					pay_mem[held] = pay & PAY_KEEP;
					held++;
				end
			end
			CMD_FIND, CMD_REMOVE_KEY: begin
				for (int i = 0; i < held; i++) begin
					if (!hit && key_mem[i] == key) begin
						hit = 1'b1;
						at  = i;
					end
				end
				if (!hit)
					a.status = STAT_NOT_FOUND;
			end
			CMD_REMOVE_IDX, CMD_READ_IDX: begin
				if (int'(pos) < held) begin
					hit = 1'b1;
					at  = int'(pos);
				end else begin
					a.status = STAT_RANGE;
				end
			end
			default: ;
		endcase
		if (hit) begin
			a.found_position = POS_W'(at);
			a.found_key      = key_mem[at];
			a.found_payload  = pay_mem[at];
			if (cmd == CMD_REMOVE_KEY || cmd == CMD_REMOVE_IDX) begin
				for (int i = at; i + 1 < held; i++) begin
					key_mem[i] = key_mem[i + 1];
					pay_mem[i] = pay_mem[i + 1];
				end
				held--;
			end
		end
		a.entry_count = CNT_W'(held);
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_answer_t want;
		list_answer_t got;
		if (!arst_n) begin
			held  = 0;
			fails = 0;
			answer_q.delete();
			pending <= 0;
		end else begin
			if (req.valid && req.ready)
				answer_q.push_back(apply_command(req.command, req.entry_key,
					req.entry_payload, req.position));
			if (rsp.valid && rsp.ready) begin
				got.status         = rsp.status;
				got.found_position = rsp.found_position;
				got.found_key      = rsp.found_key;
				got.found_payload  = rsp.found_payload;
				got.entry_count    = rsp.entry_count;
				if (answer_q.size() == 0) begin
					if (fails < 10)
						$display("%0t: unexpected result word st=%0d pos=%0d key=%h pay=%h cnt=%0d",
							$time, got.status, got.found_position, got.found_key,
							got.found_payload, got.entry_count);
					fails++;
				end else begin
					want = answer_q.pop_front();
					if (got.status !== want.status
						|| got.found_position !== want.found_position
						|| got.found_key !== want.found_key
						|| got.found_payload !== want.found_payload
						|| got.entry_count !== want.entry_count) begin
						if (fails < 10) begin
							$display("%0t: mismatch expected st=%0d pos=%0d key=%h pay=%h cnt=%0d",
								$time, want.status, want.found_position, want.found_key,
								want.found_payload, want.entry_count);
							$display("%0t:          actual   st=%0d pos=%0d key=%h pay=%h cnt=%0d",
								$time, got.status, got.found_position, got.found_key,
								got.found_payload, got.entry_count);
						end
						fails++;
					end
				end
			end
			pending <= answer_q.size();
		end
		fail_count <= fails;
	end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import kplt_pkg::*;

	typedef enum int {
		MODE_FILL,
		MODE_MIX,
		MODE_DRAIN
	} traffic_mode_t;

	localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;
	localparam logic [POS_W-1:0] POS_LAST      = '1;
	localparam logic [KEY_W-1:0] KEY_TOP       = '1;
	localparam logic [PAY_W-1:0] PAY_TOP       = '1;
	localparam int               POOL_SIZE     = 12;
	localparam int               ITEMS_PER_MODE = 190;

	logic clk;
	logic arst_n;
	logic long_stall;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   fail_count;
	int   pending;

	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	kplt_req_if req_ch ();
	kplt_rsp_if rsp_ch ();

	keyed_packed_list_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	kplt_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= !long_stall && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic send_word(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
		logic [PAY_W-1:0] pay, logic [POS_W-1:0] pos);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_ch.valid         <= 1'b1;
		req_ch.command       <= cmd;
		req_ch.entry_key     <= key;
		req_ch.entry_payload <= pay;
		req_ch.position      <= pos;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// hold the input until every result word is back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [CMD_W-1:0] pick_command(traffic_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				if (r < 62) return CMD_APPEND;
				if (r < 70) return CMD_FIND;
				if (r < 76) return CMD_REMOVE_KEY;
				if (r < 82) return CMD_REMOVE_IDX;
				if (r < 95) return CMD_READ_IDX;
			end
			MODE_MIX: begin
				if (r < 30) return CMD_APPEND;
				if (r < 45) return CMD_FIND;
				if (r < 60) return CMD_REMOVE_KEY;
				if (r < 72) return CMD_REMOVE_IDX;
				if (r < 92) return CMD_READ_IDX;
			end
			default: begin
				if (r < 10) return CMD_APPEND;
				if (r < 22) return CMD_FIND;
				if (r < 45) return CMD_REMOVE_KEY;
				if (r < 75) return CMD_REMOVE_IDX;
				if (r < 95) return CMD_READ_IDX;
			end
		endcase
		return CMD_LAST_CODE - CMD_W'($urandom_range(0, CMD_LAST_CODE - CMD_READ_IDX - 1));
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 90) return '0;
		if (r < 95) return KEY_TOP;
		return KEY_W'($urandom());
	endfunction

	function automatic logic [PAY_W-1:0] pick_payload();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return '0;
		if (r < 10) return PAY_TOP;
		return PAY_W'($urandom());
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return POS_W'($urandom_range(0, 3));
		if (r < 85) return POS_W'($urandom_range(0, 31));
		return POS_W'($urandom_range(0, POS_LAST));
	endfunction

	initial begin
		traffic_mode_t mode;
		arst_n               = 1'b0;
		long_stall           = 1'b0;
		send_idle_pct        = 0;
		recv_idle_pct        = 0;
		req_ch.valid         = 1'b0;
		req_ch.command       = CMD_APPEND;
		req_ch.entry_key     = '0;
		req_ch.entry_payload = '0;
		req_ch.position      = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(CMD_READ_IDX, '0, '0, '0);
		send_word(CMD_REMOVE_IDX, '0, '0, '0);
		send_word(CMD_FIND, '0, '0, '0);
		send_word(CMD_REMOVE_KEY, KEY_TOP, '0, '0);
		send_word(CMD_APPEND, '0, '0, POS_LAST);
		send_word(CMD_APPEND, KEY_TOP, PAY_TOP, '0);
		send_word(CMD_APPEND, '0, 32'h5555_5555, '0);
		send_word(CMD_APPEND, 31'h2AAA_AAAA, 32'hAAAA_AAAA, '0);
		send_word(CMD_FIND, '0, '0, '0);
		send_word(CMD_FIND, KEY_TOP, '0, '0);
		send_word(CMD_READ_IDX, '0, '0, 6'd3);
		send_word(CMD_READ_IDX, '0, '0, POS_LAST);
		send_word(CMD_READ_IDX, '0, '0, 6'd4);
		send_word(CMD_READ_IDX + 3'd1, KEY_TOP, PAY_TOP, POS_LAST);
		send_word(CMD_READ_IDX + 3'd2, '0, '0, '0);
		send_word(CMD_LAST_CODE, KEY_W'($urandom()), PAY_W'($urandom()), 6'd1);
		send_word(CMD_REMOVE_KEY, '0, '0, '0);
		send_word(CMD_FIND, '0, '0, '0);
		send_word(CMD_REMOVE_IDX, '0, '0, 6'd1);
		send_word(CMD_REMOVE_IDX, '0, '0, 6'd32);
		send_word(CMD_READ_IDX, '0, '0, '0);
		send_word(CMD_REMOVE_KEY, 31'h2AAA_AAAA, '0, '0);
		send_word(CMD_REMOVE_IDX, '0, '0, '0);
		send_word(CMD_REMOVE_IDX, '0, '0, '0);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 61 : 0;
			recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 22 : 0;
			for (int i = 0; i < POOL_SIZE; i++)
				key_pool[i] = KEY_W'($urandom());
			key_pool[0] = '0;
			key_pool[1] = KEY_TOP;
			if (phase == 2) begin
				fork
					begin
						long_stall <= 1'b1;
						repeat (150) @(posedge clk);
						long_stall <= 1'b0;
					end
				join_none
			end
			for (int m = 0; m < 3; m++) begin
				mode = traffic_mode_t'(m);
				for (int n = 0; n < ITEMS_PER_MODE; n++)
					send_word(pick_command(mode), pick_key(), pick_payload(),
						pick_position());
			end
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== keyed_packed_list_table_top.f =====
+incdir+src
src/kplt_pkg.sv
src/kplt_req_if.sv
src/kplt_rsp_if.sv
src/kplt_cell.sv
src/keyed_packed_list_table_top.sv
tb/kplt_checker.sv
tb/tb_top.sv
